// ----- sv/imhq_pkg.sv -----
// shared types and constants for the indexed min-heap queue
// no dependencies
package imhq_pkg;
  localparam int CAPACITY   = 512;
  localparam int MAP_CELLS  = 4096;
  localparam int DIST_WIDTH = 16;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int MAP_AW     = $clog2(MAP_CELLS);
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int MSIZE_W    = 7;
  localparam int MADDR_W    = ROW_W + MSIZE_W + 1;
  localparam logic [MSIZE_W-1:0] MAP_SIZE_RESET = 7'd64;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_LOCATE = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [DIST_WIDTH-1:0] dkey;
    logic [SLOT_W-1:0]     order;
  } entry_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [ROW_W-1:0]      cell_row;
    logic [COL_W-1:0]      cell_col;
    logic [DIST_WIDTH-1:0] item_dist;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]      top_row;
    logic [COL_W-1:0]      top_col;
    logic [DIST_WIDTH-1:0] top_dist;
    logic [SLOT_W-1:0]     top_order;
    logic [COUNT_W-1:0]    entry_count;
    logic [SLOT_W-1:0]     located_slot;
    logic                  is_empty;
    logic                  overflowed;
  } rsp_t;

  // map address, wide enough for 63*127+63
  function automatic logic [MADDR_W-1:0] map_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c,
                                                  input logic [MSIZE_W-1:0] ms);
    logic [MADDR_W-1:0] a;
    a = MADDR_W'(r) * MADDR_W'(ms) + MADDR_W'(c);
    return a;
  endfunction
endpackage

// ----- sv/imhq_if.sv -----
// valid/ready channel carrying a request or a response beat
// depends on imhq_pkg
interface imhq_req_if import imhq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface imhq_rsp_if import imhq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/imhq_heap_mem.sv -----
// heap entry store: one write port, two registered read ports
// depends on imhq_pkg
module imhq_heap_mem import imhq_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [SLOT_W-1:0] raddr_a,
  input  logic [SLOT_W-1:0] raddr_b,
  output entry_t            rdata_a,
  output entry_t            rdata_b
);
  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ----- sv/imhq_map_mem.sv -----
// position map: cell address to heap slot, one write and one read port
// depends on imhq_pkg
module imhq_map_mem import imhq_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [MAP_AW-1:0] waddr,
  input  logic [SLOT_W-1:0] wdata,
  input  logic [MAP_AW-1:0] raddr,
  output logic [SLOT_W-1:0] rdata
);
  logic [SLOT_W-1:0] mem [MAP_CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/indexed_min_heap_queue.sv -----
// indexed min-heap queue: sequencer over heap and position-map memories
// peek/locate read the root and the map; push writes the entry, then climbs a level at a time,
// stopping at the root or where the parent key is not larger; pop moves the last entry to the
// root and, unless that empties the heap, descends until no child key is smaller or none is left
// one item at a time, next request taken the cycle after the response is loaded
// rst clears count, overflow flag, map_size (to 64) and control; memories are not cleared
// depends on imhq_pkg, imhq_if, imhq_heap_mem, imhq_map_mem
module indexed_min_heap_queue import imhq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MSIZE_W-1:0] cfg_data,
  imhq_req_if.sink           req,
  imhq_rsp_if.source         rsp
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUSHWR = 4'd1;
  localparam logic [3:0] S_UPRD   = 4'd2;
  localparam logic [3:0] S_UPCMP  = 4'd3;
  localparam logic [3:0] S_UPSW   = 4'd4;
  localparam logic [3:0] S_UPSW2  = 4'd5;
  localparam logic [3:0] S_POPRD  = 4'd6;
  localparam logic [3:0] S_POPWT  = 4'd7;
  localparam logic [3:0] S_POPWR  = 4'd8;
  localparam logic [3:0] S_DNRD   = 4'd9;
  localparam logic [3:0] S_DNCMP  = 4'd10;
  localparam logic [3:0] S_DNSW   = 4'd11;
  localparam logic [3:0] S_DNSW2  = 4'd12;
  localparam logic [3:0] S_TOPRD  = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [MSIZE_W-1:0] map_size;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               ovf;
  logic               ovf_next;
  req_t               cur;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  idx_next;
  logic [SLOT_W-1:0]  oth;
  logic [SLOT_W-1:0]  oth_next;
  entry_t             ea;
  entry_t             ea_next;
  entry_t             eb;
  entry_t             eb_next;
  logic               rsp_valid;
  rsp_t               rsp_data;
  rsp_t               rsp_data_next;
  logic               rsp_load;

  logic               h_we;
  logic [SLOT_W-1:0]  h_waddr;
  entry_t             h_wdata;
  logic [SLOT_W-1:0]  h_ra;
  logic [SLOT_W-1:0]  h_rb;
  entry_t             h_da;
  entry_t             h_db;
  logic               m_we;
  logic [MAP_AW-1:0]  m_waddr;
  logic [SLOT_W-1:0]  m_wdata;
  logic [MAP_AW-1:0]  m_raddr;
  logic [SLOT_W-1:0]  m_rdata;
  logic               loc_ok;
  logic               loc_ok_next;

  logic [MADDR_W-1:0] wa_full;
  entry_t             map_ent;
  logic [SLOT_W-1:0]  map_slot;
  logic [MADDR_W-1:0] la_full;
  logic [SLOT_W:0]    lchild;
  logic [SLOT_W:0]    rchild;

  imhq_heap_mem u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr_a(h_ra), .raddr_b(h_rb), .rdata_a(h_da), .rdata_b(h_db)
  );

  imhq_map_mem u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  assign la_full = map_addr(cur.cell_row, cur.cell_col, map_size);
  assign m_raddr = la_full[MAP_AW-1:0];
  assign wa_full = map_addr(map_ent.row, map_ent.col, map_size);
  assign m_waddr = wa_full[MAP_AW-1:0];
  assign m_wdata = map_slot;
  assign lchild  = {idx, 1'b1};
  assign rchild  = {idx, 1'b1} + (SLOT_W+1)'(1);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    idx_next      = idx;
    oth_next      = oth;
    ea_next       = ea;
    eb_next       = eb;
    rsp_data_next = rsp_data;
    rsp_load      = 1'b0;
    loc_ok_next   = loc_ok;
    h_we          = 1'b0;
    h_waddr       = idx;
    h_wdata       = ea;
    h_ra          = idx;
    h_rb          = oth;
    m_we          = 1'b0;
    map_ent       = ea;
    map_slot      = idx;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_TOPRD;
          case (req.data.operation)
            OP_PUSH: begin
              if (count >= COUNT_W'(CAPACITY)) begin
                ovf_next = 1'b1;
              end else begin
                idx_next   = count[SLOT_W-1:0];
                ea_next    = '{row: req.data.cell_row, col: req.data.cell_col,
                               dkey: req.data.item_dist, order: count[SLOT_W-1:0]};
                count_next = count + COUNT_W'(1);
                state_next = S_PUSHWR;
              end
            end
            OP_POP: begin
              if (count != '0) begin
                count_next = count - COUNT_W'(1);
                oth_next   = SLOT_W'(count - COUNT_W'(1));
                state_next = S_POPRD;
              end
            end
            default: ;
          endcase
        end
      end
      // push: store new entry and its map slot, then climb
      S_PUSHWR: begin
        h_we = 1'b1;
        m_we = (wa_full < MADDR_W'(MAP_CELLS));
        if (idx == '0) begin
          state_next = S_TOPRD;
        end else begin
          oth_next   = (idx - SLOT_W'(1)) >> 1;
          state_next = S_UPRD;
        end
      end
      S_UPRD: begin
        h_rb       = oth;
        state_next = S_UPCMP;
      end
      S_UPCMP: begin
        eb_next = h_db;
        if (ea.dkey < h_db.dkey) begin
          state_next = S_UPSW;
        end else begin
          state_next = S_TOPRD;
        end
      end
      // swap: parent entry to idx first, moving entry to parent last
      S_UPSW: begin
        h_we       = 1'b1;
        h_wdata    = eb;
        map_ent    = eb;
        m_we       = (wa_full < MADDR_W'(MAP_CELLS));
        state_next = S_UPSW2;
      end
      S_UPSW2: begin
        h_we     = 1'b1;
        h_waddr  = oth;
        map_slot = oth;
        m_we     = (wa_full < MADDR_W'(MAP_CELLS));
        idx_next = oth;
        if (oth == '0) begin
          state_next = S_TOPRD;
        end else begin
          oth_next   = (oth - SLOT_W'(1)) >> 1;
          state_next = S_UPRD;
        end
      end
      S_POPRD: begin
        h_rb       = oth;
        state_next = S_POPWT;
      end
      S_POPWT: begin
        ea_next    = h_db;
        idx_next   = '0;
        state_next = S_POPWR;
      end
      // last entry goes to the root, map updated even when the heap is now empty
      S_POPWR: begin
        h_we = 1'b1;
        m_we = (wa_full < MADDR_W'(MAP_CELLS));
        if (count == '0) begin
          state_next = S_TOPRD;
        end else begin
          state_next = S_DNRD;
        end
      end
      S_DNRD: begin
        if (COUNT_W'(lchild) >= count) begin
          state_next = S_TOPRD;
        end else begin
          h_ra       = lchild[SLOT_W-1:0];
          h_rb       = rchild[SLOT_W-1:0];
          state_next = S_DNCMP;
        end
      end
      // smaller child wins, right child on a tie
      S_DNCMP: begin
        if (COUNT_W'(rchild) >= count || h_da.dkey < h_db.dkey) begin
          eb_next  = h_da;
          oth_next = lchild[SLOT_W-1:0];
          if (h_da.dkey < ea.dkey) state_next = S_DNSW;
          else state_next = S_TOPRD;
        end else begin
          eb_next  = h_db;
          oth_next = rchild[SLOT_W-1:0];
          if (h_db.dkey < ea.dkey) state_next = S_DNSW;
          else state_next = S_TOPRD;
        end
      end
      // swap down: child entry to idx first, moving entry to child last
      S_DNSW: begin
        h_we       = 1'b1;
        h_wdata    = eb;
        map_ent    = eb;
        m_we       = (wa_full < MADDR_W'(MAP_CELLS));
        state_next = S_DNSW2;
      end
      S_DNSW2: begin
        h_we       = 1'b1;
        h_waddr    = oth;
        map_slot   = oth;
        m_we       = (wa_full < MADDR_W'(MAP_CELLS));
        idx_next   = oth;
        state_next = S_DNRD;
      end
      S_TOPRD: begin
        h_ra        = '0;
        loc_ok_next = (cur.operation == OP_LOCATE) && (la_full < MADDR_W'(MAP_CELLS));
        state_next  = S_OUT;
      end
      // waits here while an older response beat is still held
      S_OUT: begin
        h_ra = '0;
        if (!rsp_valid || rsp.ready) begin
          rsp_load = 1'b1;
          rsp_data_next.entry_count  = count;
          rsp_data_next.is_empty     = (count == '0);
          rsp_data_next.overflowed   = ovf;
          rsp_data_next.located_slot = loc_ok ? m_rdata : '0;
          if (count == '0) begin
            rsp_data_next.top_row   = '0;
            rsp_data_next.top_col   = '0;
            rsp_data_next.top_dist  = '0;
            rsp_data_next.top_order = '0;
          end else begin
            rsp_data_next.top_row   = h_da.row;
            rsp_data_next.top_col   = h_da.col;
            rsp_data_next.top_dist  = h_da.dkey;
            rsp_data_next.top_order = h_da.order;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      map_size  <= MAP_SIZE_RESET;
      rsp_valid <= 1'b0;
      loc_ok    <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ovf    <= ovf_next;
      loc_ok <= loc_ok_next;
      if (cfg_we) map_size <= cfg_data;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    oth <= oth_next;
    ea  <= ea_next;
    eb  <= eb_next;
    if (req.valid && req.ready) cur <= req.data;
    if (rsp_load) rsp_data <= rsp_data_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY)) else $error("heap count beyond capacity");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf) else $error("overflow flag cleared");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("accept while busy");
  a_rsp_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)))
    else $error("empty flag mismatch");
`endif
endmodule
